// ----- hw/rtl/qte_pkg.sv -----
// Shared types, constants and arithmetic helpers for the quaternion to Euler angle unit.
`default_nettype none
package qte_pkg;

  localparam int COMPONENT_WIDTH_DEF = 32;
  localparam int CORDIC_STAGES_DEF   = 32;
  localparam int CORDIC_STAGES_MAX   = 48;

  // Square root: one result bit per stage, plus angle prep, square and difference stages.
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_LAT   = SQRT_STEPS + 3;

  localparam logic signed [63:0] ONE_Q56    = 64'sd1 <<< 56;
  localparam logic signed [31:0] HALF_PI    = 32'sd1 <<< 30;
  localparam logic [63:0]        ONE_Q62    = 64'd1 << 62;
  localparam logic [31:0]        PI_ANGLE   = 32'h8000_0000;

  typedef logic signed [63:0] rterm_t;

  typedef enum logic [1:0] {
    PITCH_NORM     = 2'd0,
    PITCH_NEG_HALF = 2'd1,
    PITCH_POS_HALF = 2'd2
  } pitch_sel_t;

  // Matrix terms that wait beside the square root pipeline.
  typedef struct packed {
    rterm_t r00;
    rterm_t r10;
    rterm_t r21;
    rterm_t r22;
    logic   ident;
  } rpass_t;

  // atan(2^-i), 2^31 = pi
  localparam logic [31:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
    32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0
  };

  // Exact Q.60 product floored to Q.56.
  function automatic rterm_t mul56(input logic signed [31:0] a, input logic signed [31:0] b);
    rterm_t p;
    p = a * b;
    return p >>> 4;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/quaternion_to_euler_angles_unit.sv -----
// Top level: quaternion in, roll / pitch / yaw binary angles out, fully pipelined.
//
// Input word: in_quat_w/x/y/z, signed Q2.30, taken when in_valid is high and
// in_stall is low. Result word: out_roll_angle, out_pitch_angle, out_yaw_angle
// (2^31 = pi), taken when out_valid is high and out_stall is low.
// Path: matrix terms, then the pitch square root (one result bit per stage), then
// the three CORDICs running side by side, and one output register. Throughput is
// one word per cycle whenever the pipeline advances (see below); the unrolled
// CORDIC and square root stages set the depth, not the rate.
// The pipeline advances as a whole whenever the output register is empty or
// being taken. While a waiting result is stalled the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; data registers are not reset.
// COMPONENT_WIDTH below 32 clears the low bits of each component first.
`default_nettype none
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_quat_w,
  input  wire logic signed [31:0] in_quat_x,
  input  wire logic signed [31:0] in_quat_y,
  input  wire logic signed [31:0] in_quat_z,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_roll_angle,
  output logic signed [31:0]      out_pitch_angle,
  output logic signed [31:0]      out_yaw_angle
);

  logic       en;
  logic       rm_valid, rm_ident;
  rterm_t     r00, r10, r20, r21, r22;
  logic       sq_valid;
  pitch_sel_t sq_sel, sel_adj, p_sel;
  logic signed [31:0] sq_a;
  logic [31:0]        sq_root;
  rpass_t     dly_r [SQRT_LAT];
  rpass_t     dly_in;
  rpass_t     dly_out;

  logic        c_roll_v, c_pitch_v, c_yaw_v;
  logic [31:0] roll_z, pitch_z, yaw_z;
  logic        roll_id, yaw_id, p_id;
  logic [2:0]  p_side;
  logic        out_valid_r;
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic signed [31:0] roll_nxt, pitch_nxt, yaw_nxt;
  logic signed [32:0] pitch_neg;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  qte_rmat #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_rmat (
    .clk, .rst_n, .en, .in_valid,
    .in_quat_w, .in_quat_x, .in_quat_y, .in_quat_z,
    .out_valid(rm_valid), .out_ident(rm_ident),
    .out_r00(r00), .out_r10(r10), .out_r20(r20), .out_r21(r21), .out_r22(r22)
  );

  qte_sqrt u_sqrt (
    .clk, .rst_n, .en, .in_valid(rm_valid), .in_r20(r20),
    .out_valid(sq_valid), .out_sel(sq_sel), .out_a(sq_a), .out_root(sq_root)
  );

  // Hold the roll and yaw terms beside the square root.
  assign dly_in  = '{r00: r00, r10: r10, r21: r21, r22: r22, ident: rm_ident};
  assign dly_out = dly_r[SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= dly_in;
      for (int k = 1; k < SQRT_LAT; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
    end
  end

  always_comb begin
    sel_adj = sq_sel;
    if (sq_sel == PITCH_NORM && sq_root == '0) begin
      sel_adj = (sq_a > 0) ? PITCH_NEG_HALF : PITCH_POS_HALF;
    end
  end

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_roll (
    .clk, .rst_n, .en, .in_valid(sq_valid),
    .in_y(dly_out.r21), .in_x(dly_out.r22), .in_side(dly_out.ident),
    .out_valid(c_roll_v), .out_angle(roll_z), .out_side(roll_id)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_yaw (
    .clk, .rst_n, .en, .in_valid(sq_valid),
    .in_y(dly_out.r10), .in_x(dly_out.r00), .in_side(dly_out.ident),
    .out_valid(c_yaw_v), .out_angle(yaw_z), .out_side(yaw_id)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(3)) u_pitch (
    .clk, .rst_n, .en, .in_valid(sq_valid),
    .in_y(rterm_t'(sq_a)), .in_x(rterm_t'({32'd0, sq_root})),
    .in_side({dly_out.ident, sel_adj}),
    .out_valid(c_pitch_v), .out_angle(pitch_z), .out_side(p_side)
  );

  assign p_id  = p_side[2];
  assign p_sel = pitch_sel_t'(p_side[1:0]);

  always_comb begin
    pitch_neg = -$signed({pitch_z[31], pitch_z});
    roll_nxt  = roll_id ? '0 : $signed(roll_z);
    yaw_nxt   = yaw_id ? '0 : $signed(yaw_z);
    case (p_sel)
      PITCH_NEG_HALF: pitch_nxt = -HALF_PI;
      PITCH_POS_HALF: pitch_nxt = HALF_PI;
      default: begin
        if (pitch_neg > 33'sd1073741824) begin
          pitch_nxt = HALF_PI;
        end else if (pitch_neg < -33'sd1073741824) begin
          pitch_nxt = -HALF_PI;
        end else begin
          pitch_nxt = pitch_neg[31:0];
        end
      end
    endcase
    if (p_id) begin
      pitch_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_roll_v & c_yaw_v & c_pitch_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r   <= yaw_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;

endmodule
`default_nettype wire

// ----- hw/rtl/qte_rmat.sv -----
// Input register, component products and rotation-matrix terms (three stages).
`default_nettype none
module qte_rmat import qte_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic signed [31:0] in_quat_w,
  input  wire logic signed [31:0] in_quat_x,
  input  wire logic signed [31:0] in_quat_y,
  input  wire logic signed [31:0] in_quat_z,
  output logic                    out_valid,
  output logic                    out_ident,
  output rterm_t                  out_r00,
  output rterm_t                  out_r10,
  output rterm_t                  out_r20,
  output rterm_t                  out_r21,
  output rterm_t                  out_r22
);

  localparam int KEEP_BITS = (COMPONENT_WIDTH < 32) ? COMPONENT_WIDTH : 32;
  localparam logic [31:0] KEEP_MASK = 32'hFFFF_FFFF << (32 - KEEP_BITS);
  localparam logic signed [34:0] ONE_Q30 = 35'sd1 <<< 30;

  logic               v0_r, v1_r, v2_r;
  logic               id0_r, id1_r, id2_r;
  logic signed [31:0] w_r, x_r, y_r, z_r;
  logic signed [31:0] w_nxt, x_nxt, y_nxt, z_nxt;
  logic signed [34:0] id_sum;
  rterm_t ww_r, xx_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  rterm_t r00_r, r10_r, r20_r, r21_r, r22_r;

  always_comb begin
    w_nxt  = in_quat_w & KEEP_MASK;
    x_nxt  = in_quat_x & KEEP_MASK;
    y_nxt  = in_quat_y & KEEP_MASK;
    z_nxt  = in_quat_z & KEEP_MASK;
    id_sum = ONE_Q30 - w_nxt - x_nxt - y_nxt - z_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r   <= w_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      id0_r <= (id_sum == '0);
      ww_r  <= mul56(w_r, w_r);
      xx_r  <= mul56(x_r, x_r);
      zz_r  <= mul56(z_r, z_r);
      xy_r  <= mul56(x_r, y_r);
      wz_r  <= mul56(w_r, z_r);
      xz_r  <= mul56(x_r, z_r);
      wy_r  <= mul56(w_r, y_r);
      yz_r  <= mul56(y_r, z_r);
      wx_r  <= mul56(w_r, x_r);
      id1_r <= id0_r;
      r00_r <= (ww_r <<< 1) - ONE_Q56 + (xx_r <<< 1);
      r10_r <= (xy_r - wz_r) <<< 1;
      r20_r <= (xz_r + wy_r) <<< 1;
      r21_r <= (yz_r - wx_r) <<< 1;
      r22_r <= (ww_r <<< 1) - ONE_Q56 + (zz_r <<< 1);
      id2_r <= id1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_ident = id2_r;
  assign out_r00   = r00_r;
  assign out_r10   = r10_r;
  assign out_r20   = r20_r;
  assign out_r21   = r21_r;
  assign out_r22   = r22_r;

endmodule
`default_nettype wire

// ----- hw/rtl/qte_sqrt.sv -----
// Pitch prep: clamp test, r20 square, 1 - r20^2 and a bit-per-stage square root.
`default_nettype none
module qte_sqrt import qte_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire rterm_t      in_r20,
  output logic             out_valid,
  output pitch_sel_t       out_sel,
  output logic signed [31:0] out_a,
  output logic [31:0]      out_root
);

  logic               va_r, vb_r;
  pitch_sel_t         sela_r, selb_r;
  logic signed [31:0] aa_r, ab_r;
  logic [63:0]        sq_r;

  logic               v_r   [SQRT_STEPS+1];
  pitch_sel_t         sel_r [SQRT_STEPS+1];
  logic signed [31:0] a_r   [SQRT_STEPS+1];
  logic [63:0]        rem_r [SQRT_STEPS+1];
  logic [63:0]        res_r [SQRT_STEPS+1];

  pitch_sel_t sel_nxt;
  logic signed [63:0] sq_nxt;

  always_comb begin
    if (in_r20 >= ONE_Q56) begin
      sel_nxt = PITCH_NEG_HALF;
    end else if (in_r20 <= -ONE_Q56) begin
      sel_nxt = PITCH_POS_HALF;
    end else begin
      sel_nxt = PITCH_NORM;
    end
    sq_nxt = aa_r * aa_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      vb_r    <= 1'b0;
      v_r[0]  <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      vb_r    <= va_r;
      v_r[0]  <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sela_r    <= sel_nxt;
      aa_r      <= in_r20[56:25];
      selb_r    <= sela_r;
      ab_r      <= aa_r;
      sq_r      <= sq_nxt;
      sel_r[0]  <= selb_r;
      a_r[0]    <= ab_r;
      rem_r[0]  <= ONE_Q62 - sq_r;
      res_r[0]  <= '0;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sel_r[k+1] <= sel_r[k];
        a_r[k+1]   <= a_r[k];
        if (rem_r[k] >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial;
          res_r[k+1] <= (res_r[k] >> 1) + BIT;
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k] >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[SQRT_STEPS];
  assign out_sel   = sel_r[SQRT_STEPS];
  assign out_a     = a_r[SQRT_STEPS];
  assign out_root  = res_r[SQRT_STEPS][31:0];

endmodule
`default_nettype wire

// ----- hw/rtl/qte_cordic.sv -----
// Unrolled vectoring CORDIC: atan2(y, x) as a binary angle, one stage per register.
`default_nettype none
module qte_cordic import qte_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire rterm_t            in_y,
  input  wire rterm_t            in_x,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  output logic [31:0]            out_angle,
  output logic [SIDE_W-1:0]      out_side
);

  logic              v_r    [STAGES+1];
  rterm_t            x_r    [STAGES+1];
  rterm_t            y_r    [STAGES+1];
  logic [31:0]       z_r    [STAGES+1];
  logic [SIDE_W-1:0] side_r [STAGES+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  // Fold the left half plane over before rotating.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      if (in_x < 0) begin
        x_r[0] <= -in_x;
        y_r[0] <= -in_y;
        z_r[0] <= PI_ANGLE;
      end else begin
        x_r[0] <= in_x;
        y_r[0] <= in_y;
        z_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[i+1] <= side_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_TAB[i];
        end else if (y_r[i] < 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i];
          y_r[i+1] <= y_r[i];
          z_r[i+1] <= z_r[i];
        end
      end
    end
  end

  assign out_valid = v_r[STAGES];
  assign out_angle = z_r[STAGES];
  assign out_side  = side_r[STAGES];

endmodule
`default_nettype wire

// ----- hw/rtl/qte_checker.sv -----
// Port-level checks for the quaternion to Euler angle unit, bound to the top level.
`default_nettype none
module qte_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] out_roll_angle,
  input wire logic signed [31:0] out_pitch_angle,
  input wire logic signed [31:0] out_yaw_angle
);

  // An empty output never back-pressures the input.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("input stalled with empty output");

  // A stalled result holds the input side too.
  a_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> in_stall) else $error("input taken while output stalled");

  // Pitch stays within plus or minus half pi.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 32'sd1073741824 &&
                   out_pitch_angle >= -32'sd1073741824))
    else $error("pitch out of range");

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_roll_angle) &&
      $stable(out_pitch_angle) && $stable(out_yaw_angle)))
    else $error("stalled output word changed");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall,
  .out_roll_angle, .out_pitch_angle, .out_yaw_angle
);
`default_nettype wire
